/* rtl/tcm_pkg.sv */
// Shared constants, register codes, state and configuration types of the touch coordinate mapper.
package tcm_pkg;

	localparam int RAW_W      = 12;
	localparam int THR_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int POSX_W     = 8;
	localparam int POSY_W     = 9;

	localparam int SCREEN_WIDTH_DEF  = 240;
	localparam int SCREEN_HEIGHT_DEF = 320;

	localparam logic [RAW_W-1:0] X_LOW_RST  = 12'd301;
	localparam logic [RAW_W-1:0] X_HIGH_RST = 12'd3796;
	localparam logic [RAW_W-1:0] Y_LOW_RST  = 12'd151;
	localparam logic [RAW_W-1:0] Y_HIGH_RST = 12'd3605;
	localparam logic [THR_W-1:0] THR_RST    = 13'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LOW,
		REG_X_HIGH,
		REG_Y_LOW,
		REG_Y_HIGH,
		REG_THRESHOLD
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_X_GO,
		ST_X_WAIT,
		ST_Y_GO,
		ST_Y_WAIT,
		ST_DECIDE
	} tcm_state_t;

	typedef struct packed {
		logic [RAW_W-1:0] x_low;
		logic [RAW_W-1:0] x_high;
		logic [RAW_W-1:0] y_low;
		logic [RAW_W-1:0] y_high;
		logic [THR_W-1:0] threshold;
	} cfg_regs_t;

endpackage

/* rtl/tcm_if.sv */
// Request channel interfaces for raw samples, mapped results and register writes.
interface tcm_sample_if;
	import tcm_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;
	modport source(output valid, output raw_x, output raw_y, input ready);
	modport sink(input valid, input raw_x, input raw_y, output ready);
endinterface

interface tcm_result_if;
	import tcm_pkg::*;
	logic              valid;
	logic              ready;
	logic [POSX_W-1:0] pos_x;
	logic [POSY_W-1:0] pos_y;
	logic              updated;
	modport source(output valid, output pos_x, output pos_y, output updated, input ready);
	modport sink(input valid, input pos_x, input pos_y, input updated, output ready);
endinterface

interface tcm_cfg_if;
	import tcm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/touch_coordinate_mapper_unit.sv */
// Top level of the touch coordinate mapper: sequencer, axis mapping and movement deadband.
// Each accepted raw sample is clamped to its calibrated window per axis and scaled onto the
// inverted display range by one shared multiply-and-divide unit, X first and then Y, and the
// held position is replaced only when the summed movement exceeds the threshold register.
// One result is delivered for every sample. The divider produces clog2(max(SCREEN_WIDTH,
// SCREEN_HEIGHT)) quotient bits per axis. The result sits in an output register, so a new
// sample is taken while the previous result still waits to be taken.
module touch_coordinate_mapper_unit #(
	parameter int SCREEN_WIDTH  = tcm_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = tcm_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tcm_cfg_if.sink       cfg,
	tcm_sample_if.sink    sample,
	tcm_result_if.source  result
);
	import tcm_pkg::*;

	localparam int XW   = $clog2(SCREEN_WIDTH);
	localparam int YW   = $clog2(SCREEN_HEIGHT);
	localparam int CW   = (XW > YW) ? XW : YW;
	localparam int SUMW = CW + 1;
	localparam int CMPW = (SUMW > THR_W) ? SUMW : THR_W;
	localparam logic [CW-1:0] TOP_X = CW'(SCREEN_WIDTH - 1);
	localparam logic [CW-1:0] TOP_Y = CW'(SCREEN_HEIGHT - 1);

	cfg_regs_t   regs;
	tcm_state_t  state_q, state_d;

	logic [RAW_W-1:0] raw_x_q, raw_y_q;
	logic [CW-1:0]    nx_q, ny_q;
	logic [XW-1:0]    held_x_q;
	logic [YW-1:0]    held_y_q;
	logic [POSX_W-1:0] pos_x_q;
	logic [POSY_W-1:0] pos_y_q;
	logic             upd_q;
	logic             out_valid_q;

	logic             axis_y;
	logic [RAW_W-1:0] ax_raw, ax_lo, ax_hi, ax_clamp, op_a, op_div;
	logic [CW-1:0]    ax_top, mapped, quot;
	logic             unit_start, unit_done;
	logic             take_sample, store_x, store_y, load_out, out_free;

	logic [XW-1:0]    new_x, dx;
	logic [YW-1:0]    new_y, dy;
	logic [SUMW-1:0]  move_sum;
	logic             moved;

	tcm_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	tcm_mul_div #(.CW(CW)) u_mul_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.op_a   (op_a),
		.op_top (ax_top),
		.op_div (op_div),
		.done   (unit_done),
		.quot   (quot)
	);

	// A reversed window clamps the raw value to one of its bounds and maps to zero.
	always_comb begin
		axis_y = (state_q == ST_Y_GO) || (state_q == ST_Y_WAIT);
		ax_raw = axis_y ? raw_y_q : raw_x_q;
		ax_lo  = axis_y ? regs.y_low : regs.x_low;
		ax_hi  = axis_y ? regs.y_high : regs.x_high;
		ax_top = axis_y ? TOP_Y : TOP_X;
		if (ax_raw < ax_lo) begin
			ax_clamp = ax_lo;
		end else if (ax_raw > ax_hi) begin
			ax_clamp = ax_hi;
		end else begin
			ax_clamp = ax_raw;
		end
		op_a   = ax_clamp - ax_lo;
		op_div = ax_hi - ax_lo;
		if (ax_hi == ax_lo) begin
			mapped = ax_top;
		end else if (ax_lo > ax_hi) begin
			mapped = '0;
		end else begin
			mapped = ax_top - quot;
		end
	end

	always_comb begin
		new_x    = XW'(nx_q);
		new_y    = YW'(ny_q);
		dx       = (new_x > held_x_q) ? new_x - held_x_q : held_x_q - new_x;
		dy       = (new_y > held_y_q) ? new_y - held_y_q : held_y_q - new_y;
		move_sum = SUMW'(dx) + SUMW'(dy);
		moved    = CMPW'(move_sum) > CMPW'(regs.threshold);
		out_free = !out_valid_q || result.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		take_sample = 1'b0;
		unit_start  = 1'b0;
		store_x     = 1'b0;
		store_y     = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				take_sample = 1'b1;
				if (sample.valid) begin
					state_d = ST_X_GO;
				end
			end
			ST_X_GO: begin
				unit_start = 1'b1;
				state_d    = ST_X_WAIT;
			end
			ST_X_WAIT: begin
				if (unit_done) begin
					store_x = 1'b1;
					state_d = ST_Y_GO;
				end
			end
			ST_Y_GO: begin
				unit_start = 1'b1;
				state_d    = ST_Y_WAIT;
			end
			ST_Y_WAIT: begin
				if (unit_done) begin
					store_y = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sample.ready   = take_sample;
	assign result.valid   = out_valid_q;
	assign result.pos_x   = pos_x_q;
	assign result.pos_y   = pos_y_q;
	assign result.updated = upd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (moved) begin
					held_x_q <= new_x;
					held_y_q <= new_y;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample && sample.valid) begin
			raw_x_q <= sample.raw_x;
			raw_y_q <= sample.raw_y;
		end
		if (store_x) begin
			nx_q <= mapped;
		end
		if (store_y) begin
			ny_q <= mapped;
		end
		if (load_out) begin
			pos_x_q <= moved ? POSX_W'(new_x) : POSX_W'(held_x_q);
			pos_y_q <= moved ? POSY_W'(new_y) : POSY_W'(held_y_q);
			upd_q   <= moved;
		end
	end
endmodule

/* rtl/tcm_cfg_regs.sv */
// Calibration window and movement threshold registers with their write port.
module tcm_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	tcm_cfg_if.sink           cfg,
	output tcm_pkg::cfg_regs_t regs
);
	import tcm_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.x_low     <= X_LOW_RST;
			regs_q.x_high    <= X_HIGH_RST;
			regs_q.y_low     <= Y_LOW_RST;
			regs_q.y_high    <= Y_HIGH_RST;
			regs_q.threshold <= THR_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_X_LOW:     regs_q.x_low     <= cfg.data[RAW_W-1:0];
				REG_X_HIGH:    regs_q.x_high    <= cfg.data[RAW_W-1:0];
				REG_Y_LOW:     regs_q.y_low     <= cfg.data[RAW_W-1:0];
				REG_Y_HIGH:    regs_q.y_high    <= cfg.data[RAW_W-1:0];
				REG_THRESHOLD: regs_q.threshold <= cfg.data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end
endmodule

/* rtl/tcm_mul_div.sv */
// Shared scaling unit: one registered multiply followed by a restoring divide, one quotient bit a cycle.
module tcm_mul_div #(
	parameter int CW = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [tcm_pkg::RAW_W-1:0] op_a,
	input  logic [CW-1:0]            op_top,
	input  logic [tcm_pkg::RAW_W-1:0] op_div,
	output logic                     done,
	output logic [CW-1:0]            quot
);
	import tcm_pkg::*;

	localparam int NW   = RAW_W + CW;
	localparam int CNTW = $clog2(CW + 1);

	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   dsh_q;
	logic [CW-1:0]   quot_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic            ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNTW'(CW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNTW'(1);
			done_q <= (cnt_q == CNTW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= NW'(op_a) * NW'(op_top);
			dsh_q  <= NW'(op_div) << (CW - 1);
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= CW'({quot_q, ge});
		end
	end
endmodule
